[hdl/fibonacci_modulo_top_macros.svh]
// Assertion macros shared by the Fibonacci modulo block.
// Defining NO_ASSERTIONS turns every macro into an empty body.
`ifndef FIBONACCI_MODULO_TOP_MACROS_SVH
`define FIBONACCI_MODULO_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FMOD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fibonacci_modulo assertion failed");
`define FMOD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fibonacci_modulo assertion failed");
`else
`define FMOD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define FMOD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/fmod_pkg.sv]
// Types shared by the Fibonacci modulo controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package fmod_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_T,
        ST_MC,
        ST_WC,
        ST_MA,
        ST_WA,
        ST_MB,
        ST_WB,
        ST_UPD,
        ST_FINISH
    } fmod_state_t;

    typedef enum logic [1:0] {
        MUL_AT,
        MUL_AA,
        MUL_BB
    } fmod_mul_sel_t;

    typedef struct packed {
        logic          load;
        logic          calc_t;
        logic          mul_start;
        logic          store;
        fmod_mul_sel_t sel;
        logic          update;
        logic          emit;
    } fmod_cmd_t;

    typedef struct packed {
        logic mod_small;
        logic bit_last;
        logic mul_busy;
        logic mul_done;
    } fmod_sts_t;

endpackage

[hdl/fmod_if.sv]
// Valid/ready channel interfaces for the Fibonacci modulo block.
// No dependencies.
`timescale 1ns / 1ps

interface fmod_in_if #(
    parameter int INDEX_BITS = 63,
    parameter int MOD_BITS   = 16
);
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] index_n;
    logic [MOD_BITS-1:0]   modulus;

    modport source (output valid, output index_n, output modulus, input ready);
    modport sink (input valid, input index_n, input modulus, output ready);
endinterface

interface fmod_out_if #(
    parameter int MOD_BITS = 16
);
    logic                valid;
    logic                ready;
    logic [MOD_BITS-1:0] fib_mod;

    modport source (output valid, output fib_mod, input ready);
    modport sink (input valid, input fib_mod, output ready);
endinterface

[hdl/fibonacci_modulo_top.sv]
// Returns F(n) mod m for each input beat, one result per beat, using fast doubling
// over the index bits with a bit-serial modular multiplier. Each index bit takes
// three modular multiplications in the shared multiplier; a modulus below 2
// answers 0. A new item is taken while the previous result still waits in the
// output register. Depends on fmod_pkg, fmod_if, fmod_ctrl and fmod_dp.
`timescale 1ns / 1ps

module fibonacci_modulo_top
    import fmod_pkg::*;
#(
    parameter int MOD_BITS   = 16,
    parameter int INDEX_BITS = 63
) (
    input logic        clk,
    input logic        rst_n,
    fmod_in_if.sink    in_ch,
    fmod_out_if.source out_ch
);

    fmod_cmd_t cmd;
    fmod_sts_t sts;

    fmod_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .out_valid(out_ch.valid),
        .out_ready(out_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fmod_dp #(
        .INDEX_BITS(INDEX_BITS),
        .MOD_BITS  (MOD_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .index_n(in_ch.index_n),
        .modulus(in_ch.modulus),
        .cmd    (cmd),
        .sts    (sts),
        .fib_mod(out_ch.fib_mod)
    );

endmodule

[hdl/fmod_mulmod.sv]
// Bit-serial modular multiplier, one multiplier bit per cycle, MSB first.
// Standalone; used by fmod_dp.
`timescale 1ns / 1ps

module fmod_mulmod #(
    parameter int MOD_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [MOD_BITS-1:0] x,
    input  logic [MOD_BITS-1:0] y,
    input  logic [MOD_BITS-1:0] m,
    output logic                busy,
    output logic                done,
    output logic [MOD_BITS-1:0] prod
);

    localparam int CNT_W = $clog2(MOD_BITS + 1);

    logic                busy_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [MOD_BITS-1:0] x_reg;
    logic [MOD_BITS-1:0] y_reg;
    logic [MOD_BITS-1:0] r_reg;
    logic [MOD_BITS:0]   dbl;
    logic [MOD_BITS:0]   sum;
    logic [MOD_BITS:0]   m_ext;

    // Each step computes r = (2r + bit * y) mod m with two conditional subtracts.
    always_comb
    begin
        m_ext = {1'b0, m};
        dbl   = {r_reg, 1'b0};
        if (dbl >= m_ext)
        begin
            dbl = dbl - m_ext;
        end
        sum = dbl + (x_reg[MOD_BITS-1] ? {1'b0, y_reg} : '0);
        if (sum >= m_ext)
        begin
            sum = sum - m_ext;
        end
    end

    assign prod = sum[MOD_BITS-1:0];
    assign busy = busy_reg;
    assign done = busy_reg && (cnt_reg == CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(MOD_BITS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (done)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x;
            y_reg <= y;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg <= {x_reg[MOD_BITS-2:0], 1'b0};
            r_reg <= prod;
        end
    end

endmodule

[hdl/fmod_dp.sv]
// Datapath for fast-doubling Fibonacci modulo m: operand registers and update logic.
// Depends on fmod_pkg and fmod_mulmod.
`timescale 1ns / 1ps

module fmod_dp
    import fmod_pkg::*;
#(
    parameter int INDEX_BITS = 63,
    parameter int MOD_BITS   = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [INDEX_BITS-1:0] index_n,
    input  logic [MOD_BITS-1:0]   modulus,
    input  fmod_cmd_t             cmd,
    output fmod_sts_t             sts,
    output logic [MOD_BITS-1:0]   fib_mod
);

    localparam int BIT_W = $clog2(INDEX_BITS);

    logic [INDEX_BITS-1:0] n_reg;
    logic [MOD_BITS-1:0]   m_reg;
    logic [MOD_BITS-1:0]   a_reg;
    logic [MOD_BITS-1:0]   b_reg;
    logic [MOD_BITS-1:0]   t_reg;
    logic [MOD_BITS-1:0]   c_reg;
    logic [MOD_BITS-1:0]   d_reg;
    logic [MOD_BITS-1:0]   fib_reg;
    logic [BIT_W-1:0]      bit_reg;

    logic [MOD_BITS-1:0]   mul_x;
    logic [MOD_BITS-1:0]   mul_y;
    logic [MOD_BITS-1:0]   prod;
    logic                  mul_busy;
    logic                  mul_done;
    logic [MOD_BITS-1:0]   two_b;
    logic [MOD_BITS-1:0]   t_next;

    function automatic logic [MOD_BITS-1:0] add_mod(
        input logic [MOD_BITS-1:0] p,
        input logic [MOD_BITS-1:0] q,
        input logic [MOD_BITS-1:0] m
    );
        logic [MOD_BITS:0] s;
        s = {1'b0, p} + {1'b0, q};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[MOD_BITS-1:0];
    endfunction

    // The difference 2F(k+1) - F(k) is taken modulo m; the wrap of x + m - a is exact.
    always_comb
    begin
        two_b = add_mod(b_reg, b_reg, m_reg);
        if (two_b >= a_reg)
        begin
            t_next = two_b - a_reg;
        end
        else
        begin
            t_next = two_b + m_reg - a_reg;
        end
    end

    always_comb
    begin
        case (cmd.sel)
            MUL_AT:
            begin
                mul_x = a_reg;
                mul_y = t_reg;
            end
            MUL_AA:
            begin
                mul_x = a_reg;
                mul_y = a_reg;
            end
            default:
            begin
                mul_x = b_reg;
                mul_y = b_reg;
            end
        endcase
    end

    fmod_mulmod #(
        .MOD_BITS(MOD_BITS)
    ) u_mulmod (
        .clk  (clk),
        .rst_n(rst_n),
        .start(cmd.mul_start),
        .x    (mul_x),
        .y    (mul_y),
        .m    (m_reg),
        .busy (mul_busy),
        .done (mul_done),
        .prod (prod)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg   <= index_n;
            m_reg   <= modulus;
            a_reg   <= '0;
            b_reg   <= MOD_BITS'(1);
            bit_reg <= BIT_W'(INDEX_BITS - 1);
        end
        if (cmd.calc_t)
        begin
            t_reg <= t_next;
        end
        if (cmd.store)
        begin
            case (cmd.sel)
                MUL_AT:  c_reg <= prod;
                MUL_AA:  d_reg <= prod;
                default: d_reg <= add_mod(d_reg, prod, m_reg);
            endcase
        end
        if (cmd.update)
        begin
            if (n_reg[bit_reg])
            begin
                a_reg <= d_reg;
                b_reg <= add_mod(c_reg, d_reg, m_reg);
            end
            else
            begin
                a_reg <= c_reg;
                b_reg <= d_reg;
            end
            if (bit_reg != '0)
            begin
                bit_reg <= bit_reg - BIT_W'(1);
            end
        end
        if (cmd.emit)
        begin
            fib_reg <= a_reg;
        end
    end

    assign sts.mod_small = (m_reg < MOD_BITS'(2));
    assign sts.bit_last  = (bit_reg == '0);
    assign sts.mul_busy  = mul_busy;
    assign sts.mul_done  = mul_done;
    assign fib_mod       = fib_reg;

endmodule

[hdl/fmod_ctrl.sv]
// Controller state machine sequencing the doubling steps and the output beat.
// Depends on fmod_pkg and fibonacci_modulo_top_macros.svh.
`timescale 1ns / 1ps
`include "fibonacci_modulo_top_macros.svh"

module fmod_ctrl
    import fmod_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  fmod_sts_t sts,
    output fmod_cmd_t cmd
);

    fmod_state_t state_reg;
    fmod_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.sel    = MUL_AT;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = sts.mod_small ? ST_FINISH : ST_T;
            end
            ST_T:
            begin
                cmd.calc_t = 1'b1;
                state_next = ST_MC;
            end
            ST_MC:
            begin
                cmd.mul_start = 1'b1;
                state_next    = ST_WC;
            end
            ST_WC:
            begin
                if (sts.mul_done)
                begin
                    cmd.store  = 1'b1;
                    state_next = ST_MA;
                end
            end
            ST_MA:
            begin
                cmd.sel       = MUL_AA;
                cmd.mul_start = 1'b1;
                state_next    = ST_WA;
            end
            ST_WA:
            begin
                cmd.sel = MUL_AA;
                if (sts.mul_done)
                begin
                    cmd.store  = 1'b1;
                    state_next = ST_MB;
                end
            end
            ST_MB:
            begin
                cmd.sel       = MUL_BB;
                cmd.mul_start = 1'b1;
                state_next    = ST_WB;
            end
            ST_WB:
            begin
                cmd.sel = MUL_BB;
                if (sts.mul_done)
                begin
                    cmd.store  = 1'b1;
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                cmd.update = 1'b1;
                state_next = sts.bit_last ? ST_FINISH : ST_T;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    `FMOD_ASSERT_SAME(a_start_when_free, clk, rst_n, cmd.mul_start, !sts.mul_busy)
    `FMOD_ASSERT_SAME(a_store_on_done, clk, rst_n, cmd.store, sts.mul_done)
    `FMOD_ASSERT_NEXT(a_emit_shows_beat, clk, rst_n, cmd.emit, out_valid)
    `FMOD_ASSERT_NEXT(a_load_then_check, clk, rst_n, cmd.load, state_reg == ST_CHECK)

endmodule

[bench/fibonacci_modulo_top_tb.sv]
// Self-checking bench for fibonacci_modulo_top: index/modulus beats in, F(n) mod m out.
// Predicts each residue by fast doubling and checks every result beat in order.
// Depends on fmod_if and fibonacci_modulo_top.
`timescale 1ns / 1ps

module fibonacci_modulo_top_tb;

    localparam int IDX_W          = 63;
    localparam int MOD_W          = 16;
    localparam int RANDOM_ITEMS   = 118;
    localparam int HOLD_CYCLES    = 10000;
    localparam int WATCHDOG_LIMIT = 50000;

    typedef struct {
        bit [IDX_W-1:0] index_n;
        bit [MOD_W-1:0] modulus;
        bit [MOD_W-1:0] residue;
    } fib_expect_t;

    logic clk;
    logic rst_n;

    fmod_in_if #(.INDEX_BITS(IDX_W), .MOD_BITS(MOD_W)) in_ch ();
    fmod_out_if #(.MOD_BITS(MOD_W)) out_ch ();

    fibonacci_modulo_top #(
        .MOD_BITS(MOD_W),
        .INDEX_BITS(IDX_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    fib_expect_t pending_residues[$];
    int          mismatch_count;
    bit          sender_idling;
    bit          drain_idling;
    int          drain_hold_req;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic bit [MOD_W-1:0] fib_residue(input bit [IDX_W-1:0] n,
                                                    input bit [MOD_W-1:0] m);
        bit [63:0] mm;
        bit [63:0] f_k;
        bit [63:0] f_k1;
        bit [63:0] twice;
        bit [63:0] even_term;
        bit [63:0] odd_term;
        mm = 64'(m);
        if (mm < 64'd2)
        begin
            return '0;
        end
        f_k  = 64'd0;
        f_k1 = 64'd1;
        for (int i = IDX_W - 1; i >= 0; i--)
        begin
            twice     = (64'd2 * f_k1 + mm - f_k) % mm;
            even_term = (f_k * twice) % mm;
            odd_term  = ((f_k * f_k) % mm + (f_k1 * f_k1) % mm) % mm;
            if (n[i])
            begin
                f_k  = odd_term;
                f_k1 = (even_term + odd_term) % mm;
            end
            else
            begin
                f_k  = even_term;
                f_k1 = odd_term;
            end
        end
        return f_k[MOD_W-1:0];
    endfunction

    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom_range(20, 200);
        end
        return $urandom_range(0, 3);
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t: %s", $time, what);
    endtask

    // Called and returns at a falling edge.
    task automatic send_item(input bit [IDX_W-1:0] n, input bit [MOD_W-1:0] m);
        int          gap;
        fib_expect_t entry;
        gap = sender_idling ? idle_len() : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.index_n <= n;
        in_ch.modulus <= m;
        do
            @(posedge clk);
        while (!in_ch.ready);
        entry.index_n = n;
        entry.modulus = m;
        entry.residue = fib_residue(n, m);
        pending_residues.push_back(entry);
        @(negedge clk);
    endtask

    // Called at a falling edge; stops offering beats and waits for every result.
    task automatic wait_for_drain();
        in_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_residues.size() != 0);
    endtask

    task automatic test_index_extremes();
        bit [IDX_W-1:0] alt;
        alt = IDX_W'({(IDX_W + 1) / 2{2'b10}});
        send_item('0, 16'd65535);
        send_item(63'd1, 16'd65535);
        send_item(63'd2, 16'd65535);
        send_item('1, 16'd65535);
        send_item(63'd1 << (IDX_W - 1), 16'd65521);
        send_item(alt, 16'd40961);
        send_item(~alt, 16'd40961);
        send_item(63'd93, 16'd65534);
    endtask

    task automatic test_modulus_corners();
        send_item('1, 16'd0);
        send_item(63'd12345, 16'd0);
        send_item('1, 16'd1);
        send_item(63'd3, 16'd2);
        send_item('1, 16'd2);
        send_item('1, 16'd3);
        send_item(63'd60, 16'd10);
        send_item('1, 16'd32768);
        send_item(63'h2AAA_5555_1234_ABCD, 16'd65535);
        send_item('0, 16'd1);
    endtask

    // The receiver holds off long enough for the block to fill and refuse input.
    task automatic test_output_backpressure();
        sender_idling  = 1'b0;
        drain_hold_req = HOLD_CYCLES;
        for (int i = 0; i < 4; i++)
        begin
            send_item(IDX_W'({$urandom, $urandom}), MOD_W'($urandom_range(2, 65535)));
        end
        wait_for_drain();
        sender_idling = 1'b1;
    endtask

    task automatic test_random_items();
        bit [63:0]      raw;
        bit [31:0]      mraw;
        bit [IDX_W-1:0] n;
        bit [MOD_W-1:0] m;
        int             pick;
        sender_idling = 1'b0;
        drain_idling  = 1'b0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 20)
            begin
                sender_idling = 1'b1;
                drain_idling  = 1'b1;
            end
            raw  = {$urandom, $urandom};
            n    = raw[IDX_W-1:0] >> $urandom_range(0, IDX_W - 1);
            mraw = $urandom;
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                m = MOD_W'($urandom_range(0, 1));
            end
            else if (pick == 1)
            begin
                m = '1;
            end
            else
            begin
                m = mraw[MOD_W-1:0] >> $urandom_range(0, MOD_W - 2);
            end
            send_item(n, m);
        end
    endtask

    initial
    begin : residue_checker
        fib_expect_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                if (pending_residues.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected beat fib_mod=%0d", out_ch.fib_mod));
                end
                else
                begin
                    want = pending_residues.pop_front();
                    if (out_ch.fib_mod !== want.residue)
                    begin
                        report_mismatch($sformatf("n=%0d m=%0d: fib_mod=%0d, want %0d",
                            want.index_n, want.modulus, out_ch.fib_mod, want.residue));
                    end
                end
            end
        end
    end

    initial
    begin : result_drain
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (drain_hold_req != 0)
            begin
                hold_left      = drain_hold_req;
                drain_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (drain_idling && $urandom_range(0, 2) == 0)
                begin
                    stall_left = idle_len();
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("fibonacci_modulo_top: mismatch");
        $finish;
    end

    initial
    begin : test_sequence
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.index_n  = '0;
        in_ch.modulus  = '0;
        out_ch.ready   = 1'b0;
        mismatch_count = 0;
        sender_idling  = 1'b1;
        drain_idling   = 1'b1;
        drain_hold_req = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_index_extremes();
        test_modulus_corners();
        test_output_backpressure();
        test_random_items();
        wait_for_drain();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("fibonacci_modulo_top: match");
        end
        else
        begin
            $display("fibonacci_modulo_top: mismatch");
        end
        $finish;
    end

endmodule
